>>> hdl/sftts_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the glyph stroke table for the stroke font text generator.
// No dependencies; every other file of the block imports this package.
package sftts_pkg;

    // Coordinate and grid sizes
    localparam int COORD_BITS_DEF = 16;
    localparam int GLYPH_WIDTH    = 3;
    localparam int GLYPH_HEIGHT   = 3;
    localparam int STEP_W         = 13;
    localparam int POS_W          = 16;
    localparam int CHAR_W         = 8;
    localparam int CFG_W          = 8;
    localparam int N_LETTERS      = 26;
    localparam int MAX_STROKES    = 6;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_GLYPH_SCALE = 2'd0;
    localparam logic [1:0] REG_MARGIN_X    = 2'd1;
    localparam logic [1:0] REG_MARGIN_Y    = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 8'd1;

    // Request opcodes
    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] CH_UP_A    = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UP_Z    = 8'd90;
    localparam logic [CHAR_W-1:0] CH_LO_A    = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LO_Z    = 8'd122;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0] glyph_scale;
        logic [CFG_W-1:0] margin_x;
        logic [CFG_W-1:0] margin_y;
    } t_cfg;

    typedef struct packed {
        logic in_ready;
        logic set_pos;
        logic adv_x;
        logic adv_line;
        logic load_char;
        logic emit_seg;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic op;
        logic is_letter;
        logic is_space;
        logic is_newline;
        logic last_stroke;
        logic out_free;
    } t_dp_status;

    // One stroke on the 3 by 3 grid, coordinates 0..2
    typedef struct packed {
        logic [1:0] x0;
        logic [1:0] y0;
        logic [1:0] x1;
        logic [1:0] y1;
    } t_stroke;

    localparam logic [2:0] STROKE_CNT [N_LETTERS] = '{
        3'd4, 3'd6, 3'd3, 3'd5, 3'd4, 3'd3, 3'd5, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd4, 3'd6, 3'd5, 3'd5, 3'd2, 3'd3, 3'd2, 3'd4, 3'd2, 3'd3, 3'd4
    };

    // Each entry packs x0, y0, x1, y1 as two bits apiece
    localparam t_stroke STROKE_TAB [N_LETTERS][MAX_STROKES] = '{
        '{8'b00_00_00_10, 8'b10_00_10_10, 8'b00_00_10_00,
          8'b00_01_10_01, 8'h00,          8'h00},
        '{8'b00_00_00_10, 8'b10_01_10_10, 8'b00_00_10_00,
          8'b00_01_10_01, 8'b00_10_10_10, 8'b01_01_10_00},
        '{8'b00_00_00_10, 8'b00_00_10_00, 8'b00_10_10_10,
          8'h00,          8'h00,          8'h00},
        '{8'b00_00_00_10, 8'b10_00_10_01, 8'b00_00_10_00,
          8'b00_10_01_10, 8'b01_10_10_01, 8'h00},
        '{8'b00_00_00_10, 8'b00_00_10_00, 8'b00_01_01_01,
          8'b00_10_10_10, 8'h00,          8'h00},
        '{8'b00_00_00_10, 8'b00_00_10_00, 8'b00_01_01_01,
          8'h00,          8'h00,          8'h00},
        '{8'b00_00_00_10, 8'b10_01_10_10, 8'b00_00_10_00,
          8'b01_01_10_01, 8'b00_10_10_10, 8'h00},
        '{8'b00_00_00_10, 8'b10_00_10_10, 8'b00_01_10_01,
          8'h00,          8'h00,          8'h00},
        '{8'b01_00_01_10, 8'b00_00_10_00, 8'b00_10_10_10,
          8'h00,          8'h00,          8'h00},
        '{8'b00_01_00_10, 8'b10_00_10_10, 8'b00_10_10_10,
          8'h00,          8'h00,          8'h00},
        '{8'b00_00_00_10, 8'b00_01_10_00, 8'b00_01_10_10,
          8'h00,          8'h00,          8'h00},
        '{8'b00_00_00_10, 8'b00_10_10_10, 8'h00,
          8'h00,          8'h00,          8'h00},
        '{8'b00_00_00_10, 8'b10_00_10_10, 8'b00_00_01_10,
          8'b01_10_10_00, 8'h00,          8'h00},
        '{8'b00_00_00_10, 8'b10_00_10_10, 8'b00_00_10_10,
          8'h00,          8'h00,          8'h00},
        '{8'b00_00_00_10, 8'b10_00_10_10, 8'b00_00_10_00,
          8'b00_10_10_10, 8'h00,          8'h00},
        '{8'b00_00_00_10, 8'b10_00_10_01, 8'b00_00_10_00,
          8'b00_01_10_01, 8'h00,          8'h00},
        '{8'b00_00_00_10, 8'b10_00_10_01, 8'b00_00_10_00,
          8'b00_10_01_10, 8'b01_01_10_10, 8'b01_10_10_01},
        '{8'b00_00_00_10, 8'b10_00_10_01, 8'b00_00_10_00,
          8'b00_01_10_01, 8'b01_01_10_10, 8'h00},
        '{8'b00_00_00_01, 8'b10_01_10_10, 8'b00_00_10_00,
          8'b00_01_10_01, 8'b00_10_10_10, 8'h00},
        '{8'b01_00_01_10, 8'b00_00_10_00, 8'h00,
          8'h00,          8'h00,          8'h00},
        '{8'b00_00_00_10, 8'b10_00_10_10, 8'b00_10_10_10,
          8'h00,          8'h00,          8'h00},
        '{8'b00_00_01_10, 8'b01_10_10_00, 8'h00,
          8'h00,          8'h00,          8'h00},
        '{8'b00_00_00_10, 8'b10_00_10_10, 8'b00_10_01_01,
          8'b01_01_10_10, 8'h00,          8'h00},
        '{8'b00_00_10_10, 8'b00_10_10_00, 8'h00,
          8'h00,          8'h00,          8'h00},
        '{8'b01_01_01_10, 8'b00_00_01_01, 8'b01_01_10_00,
          8'h00,          8'h00,          8'h00},
        '{8'b00_00_10_00, 8'b00_01_10_01, 8'b00_10_10_10,
          8'b00_10_10_00, 8'h00,          8'h00}
    };

endpackage

>>> hdl/sftts_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: character requests in, line segments out.
// Depends on sftts_pkg for field widths.
interface sftts_in_if;
    import sftts_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;

    modport source (output valid, op, char_code, pos_x, pos_y, input ready);
    modport sink   (input valid, op, char_code, pos_x, pos_y, output ready);
endinterface

interface sftts_out_if;
    import sftts_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] seg_x_start;
    logic [POS_W-1:0] seg_y_start;
    logic [POS_W-1:0] seg_x_end;
    logic [POS_W-1:0] seg_y_end;
    logic             last_segment;

    modport source (output valid, seg_x_start, seg_y_start, seg_x_end, seg_y_end,
                    last_segment, input ready);
    modport sink   (input valid, seg_x_start, seg_y_start, seg_x_end, seg_y_end,
                    last_segment, output ready);
endinterface

>>> hdl/stroke_font_text_to_segments_top.sv
`timescale 1ns / 1ps
// Top level of the stroke font text generator: register file, controller and datapath.
// Depends on sftts_pkg, sftts_if.sv, sftts_cfg, sftts_ctrl and sftts_dp.
//
// Usage
//   i_char carries one request per handshake: op 0 draws char_code, op 1 sets the
//   cursor and the line start to pos_x / pos_y. o_seg gives one line segment per
//   handshake, last_segment marking the final stroke of a letter.
//   The APB port writes glyph_scale (0x0), margin_x (0x4) and margin_y (0x8); write
//   it only while no letter is in flight.
// Sequence
//   A cursor command, space, newline or ignored code is taken in idle and emits
//   nothing. A letter with n strokes (2 to 6) holds the request side while it is
//   decoded and loaded, then walked one stroke per cycle, while the output stage
//   can take it, through the stroke table and the endpoint adders. The first segment
//   is valid once the request has passed the state register and then the segment
//   register; the next request is taken while the last segment still waits.
// Reset
//   Synchronous, active low: cursor and line start go to 0, the three configuration
//   registers to 1, and the output stage empties.
// Back-pressure
//   While a held segment waits with o_seg.ready low, the segment register holds and
//   the stroke walk waits; no segment is dropped or repeated.
module stroke_font_text_to_segments_top #(
    parameter int COORD_BITS = sftts_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sftts_pkg::PADDR_W-1:0] paddr,
    input  logic [sftts_pkg::PDATA_W-1:0] pwdata,
    output logic [sftts_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    sftts_in_if.sink                      i_char,
    sftts_out_if.source                   o_seg
);
    import sftts_pkg::*;

    t_cfg       w_cfg;
    t_dp_cmd    w_cmd;
    t_dp_status w_sts;

    // Registers: live values feed the datapath directly
    sftts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer: idle decode, then walk strokes one per cycle while the output stage can take them
    sftts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Cursor arithmetic, stroke table and output register
    sftts_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_char  (i_char),
        .o_seg   (o_seg)
    );

endmodule

>>> hdl/sftts_cfg.sv
`timescale 1ns / 1ps
// APB-style register file: glyph scale and the two margins.
// Depends on sftts_pkg.
module sftts_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sftts_pkg::PADDR_W-1:0] paddr,
    input  logic [sftts_pkg::PDATA_W-1:0] pwdata,
    output logic [sftts_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output sftts_pkg::t_cfg              o_cfg
);
    import sftts_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glyph_scale <= CFG_RESET;
            r_cfg.margin_x    <= CFG_RESET;
            r_cfg.margin_y    <= CFG_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_GLYPH_SCALE: r_cfg.glyph_scale <= pwdata[CFG_W-1:0];
                REG_MARGIN_X:    r_cfg.margin_x    <= pwdata[CFG_W-1:0];
                REG_MARGIN_Y:    r_cfg.margin_y    <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_GLYPH_SCALE: prdata = PDATA_W'(r_cfg.glyph_scale);
            REG_MARGIN_X:    prdata = PDATA_W'(r_cfg.margin_x);
            REG_MARGIN_Y:    prdata = PDATA_W'(r_cfg.margin_y);
            default:         prdata = '0;
        endcase
    end

endmodule

>>> hdl/sftts_ctrl.sv
`timescale 1ns / 1ps
// Controller: decides per request whether to move the cursor or walk the strokes.
// Depends on sftts_pkg; drives the datapath only through t_dp_cmd.
module sftts_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sftts_pkg::t_dp_status i_sts,
    output sftts_pkg::t_dp_cmd    o_cmd
);
    import sftts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    if (i_sts.op == OP_SET) begin
                        o_cmd.set_pos = 1'b1;
                    end else if (i_sts.is_newline) begin
                        o_cmd.adv_line = 1'b1;
                    end else if (i_sts.is_space) begin
                        o_cmd.adv_x = 1'b1;
                    end else if (i_sts.is_letter) begin
                        o_cmd.load_char = 1'b1;
                        n_state         = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                // one stroke per cycle while the output stage can take it
                if (i_sts.out_free) begin
                    o_cmd.emit_seg = 1'b1;
                    if (i_sts.last_stroke) begin
                        o_cmd.adv_x = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_load_enters_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_char |=> (r_state == ST_EMIT))
        else $error("letter load did not start stroke walk");

    a_stall_holds_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !i_sts.out_free) |=> (r_state == ST_EMIT))
        else $error("stroke walk left while output stalled");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_seg && i_sts.last_stroke) |=> (r_state == ST_IDLE))
        else $error("no return to idle after last stroke");

endmodule

>>> hdl/sftts_dp.sv
`timescale 1ns / 1ps
// Datapath: cursor registers, character decode, stroke lookup and output stage.
// Depends on sftts_pkg and the channel interfaces in sftts_if.sv.
module sftts_dp #(
    parameter int COORD_BITS = sftts_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sftts_pkg::t_cfg       i_cfg,
    input  sftts_pkg::t_dp_cmd    i_cmd,
    output sftts_pkg::t_dp_status o_sts,
    sftts_in_if.sink              i_char,
    sftts_out_if.source           o_seg
);
    import sftts_pkg::*;

    logic [COORD_BITS-1:0] r_cursor_x;
    logic [COORD_BITS-1:0] r_cursor_y;
    logic [COORD_BITS-1:0] r_line_x;
    logic [4:0]            r_letter;
    logic [2:0]            r_count;
    logic [2:0]            r_stroke;
    logic                  r_out_valid;
    logic [POS_W-1:0]      r_xs;
    logic [POS_W-1:0]      r_ys;
    logic [POS_W-1:0]      r_xe;
    logic [POS_W-1:0]      r_ye;
    logic                  r_last;

    logic                  w_upper;
    logic                  w_lower;
    logic [4:0]            w_letter;
    logic                  w_last;
    t_stroke               w_stroke;
    logic [COORD_BITS-1:0] w_step_x;
    logic [COORD_BITS-1:0] w_step_y;
    logic [COORD_BITS-1:0] w_xs;
    logic [COORD_BITS-1:0] w_ys;
    logic [COORD_BITS-1:0] w_xe;
    logic [COORD_BITS-1:0] w_ye;

    // grid coordinate 0..2 times scale, by selection and shift
    function automatic logic [CFG_W:0] f_scale(input logic [1:0] c, input logic [CFG_W-1:0] s);
        logic [CFG_W:0] v;
        case (c)
            2'd1:    v = {1'b0, s};
            2'd2:    v = {s, 1'b0};
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        w_upper  = (i_char.char_code inside {[CH_UP_A:CH_UP_Z]});
        w_lower  = (i_char.char_code inside {[CH_LO_A:CH_LO_Z]});
        w_letter = w_upper ? 5'(i_char.char_code - CH_UP_A) : 5'(i_char.char_code - CH_LO_A);
    end

    assign w_step_x = COORD_BITS'(STEP_W'(GLYPH_WIDTH) * STEP_W'(i_cfg.glyph_scale))
                    + COORD_BITS'(i_cfg.margin_x) - COORD_BITS'(1);
    assign w_step_y = COORD_BITS'(STEP_W'(GLYPH_HEIGHT) * STEP_W'(i_cfg.glyph_scale))
                    + COORD_BITS'(i_cfg.margin_y) - COORD_BITS'(1);

    assign w_stroke = STROKE_TAB[r_letter][r_stroke];
    assign w_last   = (r_stroke == r_count - 3'd1);

    assign w_xs = COORD_BITS'(f_scale(w_stroke.x0, i_cfg.glyph_scale)) + r_cursor_x;
    assign w_ys = COORD_BITS'(f_scale(w_stroke.y0, i_cfg.glyph_scale)) + r_cursor_y;
    assign w_xe = COORD_BITS'(f_scale(w_stroke.x1, i_cfg.glyph_scale)) + r_cursor_x;
    assign w_ye = COORD_BITS'(f_scale(w_stroke.y1, i_cfg.glyph_scale)) + r_cursor_y;

    assign o_sts.in_valid    = i_char.valid;
    assign o_sts.op          = i_char.op;
    assign o_sts.is_letter   = w_upper | w_lower;
    assign o_sts.is_space    = (i_char.char_code == CH_SPACE);
    assign o_sts.is_newline  = (i_char.char_code == CH_NEWLINE);
    assign o_sts.last_stroke = w_last;
    assign o_sts.out_free    = !r_out_valid || o_seg.ready;

    assign i_char.ready       = i_cmd.in_ready;
    assign o_seg.valid        = r_out_valid;
    assign o_seg.seg_x_start  = r_xs;
    assign o_seg.seg_y_start  = r_ys;
    assign o_seg.seg_x_end    = r_xe;
    assign o_seg.seg_y_end    = r_ye;
    assign o_seg.last_segment = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x  <= '0;
            r_cursor_y  <= '0;
            r_line_x    <= '0;
            r_stroke    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.set_pos) begin
                r_cursor_x <= COORD_BITS'(i_char.pos_x);
                r_line_x   <= COORD_BITS'(i_char.pos_x);
                r_cursor_y <= COORD_BITS'(i_char.pos_y);
            end
            if (i_cmd.adv_line) begin
                r_cursor_x <= r_line_x;
                r_cursor_y <= r_cursor_y + w_step_y;
            end
            if (i_cmd.adv_x) begin
                r_cursor_x <= r_cursor_x + w_step_x;
            end
            if (i_cmd.load_char) begin
                r_stroke <= '0;
            end else if (i_cmd.emit_seg) begin
                r_stroke <= r_stroke + 3'd1;
            end
            if (i_cmd.emit_seg) begin
                r_out_valid <= 1'b1;
            end else if (o_seg.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char) begin
            r_letter <= w_letter;
            r_count  <= STROKE_CNT[w_letter];
        end
        if (i_cmd.emit_seg) begin
            r_xs   <= POS_W'(w_xs);
            r_ys   <= POS_W'(w_ys);
            r_xe   <= POS_W'(w_xe);
            r_ye   <= POS_W'(w_ye);
            r_last <= w_last;
        end
    end

    a_stroke_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_seg |-> (r_stroke < r_count))
        else $error("stroke index beyond letter stroke count");

    a_last_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_seg && w_last) |=> (o_seg.valid && o_seg.last_segment))
        else $error("final stroke not marked last");

    a_cursor_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_seg && !w_last) |=> ($stable(r_cursor_x) && $stable(r_cursor_y)))
        else $error("cursor moved in the middle of a letter");

endmodule
